// ===== hw/rtl/whs_pkg.sv =====
// ----------------------------------------------------------------------------
// whs_pkg
// shared types, constants and register map of the heater sequencer
// ----------------------------------------------------------------------------
package whs_pkg;

	// heater voltage limits, millivolts
	localparam int MAX_HEATER_MV = 12000;
	localparam int PREHEAT_MV    = 2000;
	localparam int PREHEAT_VOLTS = (PREHEAT_MV > MAX_HEATER_MV) ? MAX_HEATER_MV : PREHEAT_MV;

	// internal voltage width, covers the full clamp range
	localparam int VOLT_W = 15;
	localparam int TICK_W = 24;
	localparam int RAMP_W = 16;
	localparam int DUTY_W = 16;
	localparam int VB_W   = 15;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// duty divider
	localparam int DIV_STEPS = DUTY_W;
	localparam int SQ_W      = 2 * VOLT_W;

	// queue between sequencer and duty unit
	localparam int QUEUE_DEPTH = 2;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [0:0]        RST_ENABLE         = 1'b0;
	localparam logic [TICK_W-1:0] RST_PREHEAT_TICKS  = 24'd100;
	localparam logic [TICK_W-1:0] RST_WARMUP_TIMEOUT = 24'd500;
	localparam logic [13:0]       RST_WARMUP_INIT    = 14'd7000;
	localparam logic [9:0]        RST_WARMUP_STEP    = 10'd20;
	localparam logic [12:0]       RST_UR_READY       = 13'd2000;
	localparam logic [12:0]       RST_UR_OVERHEAT    = 13'd500;
	localparam logic [12:0]       RST_UR_UNDERHEAT   = 13'd2200;

	typedef enum logic [2:0] {
		REG_ENABLE         = 3'd0,
		REG_PREHEAT_TICKS  = 3'd1,
		REG_WARMUP_TIMEOUT = 3'd2,
		REG_WARMUP_INIT    = 3'd3,
		REG_WARMUP_STEP    = 3'd4,
		REG_UR_READY       = 3'd5,
		REG_UR_OVERHEAT    = 3'd6,
		REG_UR_UNDERHEAT   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_DISABLED = 3'd0,
		ST_IDLE     = 3'd1,
		ST_PREHEAT  = 3'd2,
		ST_WARMUP   = 3'd3,
		ST_RUNNING  = 3'd4,
		ST_ERROR    = 3'd5
	} sensor_state_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_TIMEOUT   = 2'd1,
		ERR_OVERHEAT  = 2'd2,
		ERR_UNDERHEAT = 2'd3
	} err_code_t;

	typedef enum logic [1:0] {
		B_IDLE   = 2'd0,
		B_SQUARE = 2'd1,
		B_DIVIDE = 2'd2,
		B_DONE   = 2'd3
	} back_state_t;

	typedef struct packed {
		logic               enable;
		logic [TICK_W-1:0]  preheat_ticks;
		logic [TICK_W-1:0]  warmup_timeout_ticks;
		logic [13:0]        warmup_initial_mv;
		logic [9:0]         warmup_step_mv;
		logic [12:0]        ur_ready_mv;
		logic [12:0]        ur_overheat_mv;
		logic [12:0]        ur_underheat_mv;
	} cfg_t;

	typedef struct packed {
		logic [12:0]        ur_mv;
		logic               engine_turning;
		logic signed [15:0] pid_mv;
		logic [14:0]        vbatt_mv;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  sensor_state_out;
		logic [1:0]  error_code;
		logic [13:0] heater_mv;
		logic [15:0] heater_duty;
	} out_item_t;

	// one classified tick, handed from sequencer to duty unit
	typedef struct packed {
		sensor_state_t     state;
		err_code_t         err;
		logic [VOLT_W-1:0] volts;
		logic [VB_W-1:0]   vbatt;
	} job_t;

endpackage

// ===== hw/rtl/whs_regs.sv =====
// ----------------------------------------------------------------------------
// whs_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module whs_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [whs_pkg::PADDR_W-1:0]   paddr,
	input  logic [whs_pkg::PDATA_W-1:0]   pwdata,
	output logic [whs_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output whs_pkg::cfg_t                 cfg
);

	whs_pkg::cfg_t     cfg_q;
	whs_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = whs_pkg::reg_idx_t'(paddr[whs_pkg::PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable               <= whs_pkg::RST_ENABLE;
			cfg_q.preheat_ticks        <= whs_pkg::RST_PREHEAT_TICKS;
			cfg_q.warmup_timeout_ticks <= whs_pkg::RST_WARMUP_TIMEOUT;
			cfg_q.warmup_initial_mv    <= whs_pkg::RST_WARMUP_INIT;
			cfg_q.warmup_step_mv       <= whs_pkg::RST_WARMUP_STEP;
			cfg_q.ur_ready_mv          <= whs_pkg::RST_UR_READY;
			cfg_q.ur_overheat_mv       <= whs_pkg::RST_UR_OVERHEAT;
			cfg_q.ur_underheat_mv      <= whs_pkg::RST_UR_UNDERHEAT;
		end else if (wr_en) begin
			case (idx)
				whs_pkg::REG_ENABLE:         cfg_q.enable               <= pwdata[0];
				whs_pkg::REG_PREHEAT_TICKS:  cfg_q.preheat_ticks        <= pwdata[23:0];
				whs_pkg::REG_WARMUP_TIMEOUT: cfg_q.warmup_timeout_ticks <= pwdata[23:0];
				whs_pkg::REG_WARMUP_INIT:    cfg_q.warmup_initial_mv    <= pwdata[13:0];
				whs_pkg::REG_WARMUP_STEP:    cfg_q.warmup_step_mv       <= pwdata[9:0];
				whs_pkg::REG_UR_READY:       cfg_q.ur_ready_mv          <= pwdata[12:0];
				whs_pkg::REG_UR_OVERHEAT:    cfg_q.ur_overheat_mv       <= pwdata[12:0];
				whs_pkg::REG_UR_UNDERHEAT:   cfg_q.ur_underheat_mv      <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			whs_pkg::REG_ENABLE:         prdata = 32'(cfg_q.enable);
			whs_pkg::REG_PREHEAT_TICKS:  prdata = 32'(cfg_q.preheat_ticks);
			whs_pkg::REG_WARMUP_TIMEOUT: prdata = 32'(cfg_q.warmup_timeout_ticks);
			whs_pkg::REG_WARMUP_INIT:    prdata = 32'(cfg_q.warmup_initial_mv);
			whs_pkg::REG_WARMUP_STEP:    prdata = 32'(cfg_q.warmup_step_mv);
			whs_pkg::REG_UR_READY:       prdata = 32'(cfg_q.ur_ready_mv);
			whs_pkg::REG_UR_OVERHEAT:    prdata = 32'(cfg_q.ur_overheat_mv);
			whs_pkg::REG_UR_UNDERHEAT:   prdata = 32'(cfg_q.ur_underheat_mv);
			default:                     prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/whs_front.sv =====
// ----------------------------------------------------------------------------
// whs_front
// tick sequencer: state transitions, tick counting, ramp and voltage select
// ----------------------------------------------------------------------------
module whs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  whs_pkg::cfg_t     cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  whs_pkg::in_item_t item,
	input  logic              queue_full,
	output logic              push,
	output whs_pkg::job_t     job
);

	whs_pkg::sensor_state_t         state_q, state_d;
	whs_pkg::err_code_t             err_q, err_d;
	logic [whs_pkg::TICK_W-1:0]     ticks_q, ticks_d, elapsed;
	logic [whs_pkg::RAMP_W-1:0]     ramp_q, ramp_d, ramp_base;
	logic [whs_pkg::RAMP_W:0]       ramp_sum;
	logic [whs_pkg::VOLT_W-1:0]     volts;

	assign item_ready = !queue_full;
	assign push       = item_valid && item_ready;
	assign elapsed    = (ticks_q == whs_pkg::TICK_MAX) ? ticks_q : ticks_q + 1'b1;

	// next state and error latch
	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		if (!cfg.enable) begin
			state_d = whs_pkg::ST_DISABLED;
		end else begin
			case (state_q)
				whs_pkg::ST_IDLE: begin
					state_d = item.engine_turning ? whs_pkg::ST_PREHEAT : whs_pkg::ST_IDLE;
				end
				whs_pkg::ST_PREHEAT: begin
					if (!item.engine_turning)
						state_d = whs_pkg::ST_IDLE;
					else if (elapsed > cfg.preheat_ticks)
						state_d = whs_pkg::ST_WARMUP;
				end
				whs_pkg::ST_WARMUP: begin
					if (!item.engine_turning) begin
						state_d = whs_pkg::ST_IDLE;
					end else if (elapsed > cfg.warmup_timeout_ticks) begin
						state_d = whs_pkg::ST_ERROR;
						err_d   = whs_pkg::ERR_TIMEOUT;
					end else if (item.ur_mv < cfg.ur_ready_mv) begin
						state_d = whs_pkg::ST_RUNNING;
					end
				end
				whs_pkg::ST_RUNNING: begin
					if (!item.engine_turning) begin
						state_d = whs_pkg::ST_IDLE;
					end else if (item.ur_mv < cfg.ur_overheat_mv) begin
						state_d = whs_pkg::ST_ERROR;
						err_d   = whs_pkg::ERR_OVERHEAT;
					end else if (item.ur_mv > cfg.ur_underheat_mv) begin
						state_d = whs_pkg::ST_ERROR;
						err_d   = whs_pkg::ERR_UNDERHEAT;
					end
				end
				whs_pkg::ST_ERROR: state_d = whs_pkg::ST_ERROR;
				default:           state_d = whs_pkg::ST_DISABLED;
			endcase
		end
	end

	// tick count, ramp and heater voltage for the new state
	always_comb begin
		ticks_d   = (state_d != state_q) ? '0 : elapsed;
		ramp_base = (state_d != state_q) ? whs_pkg::RAMP_W'(cfg.warmup_initial_mv) : ramp_q;
		ramp_sum  = {1'b0, ramp_base} + (whs_pkg::RAMP_W + 1)'(cfg.warmup_step_mv);
		ramp_d    = ramp_q;
		volts     = '0;
		case (state_d)
			whs_pkg::ST_PREHEAT: begin
				volts = whs_pkg::VOLT_W'(whs_pkg::PREHEAT_VOLTS);
			end
			whs_pkg::ST_WARMUP: begin
				ramp_d = ramp_sum[whs_pkg::RAMP_W] ? '1 : ramp_sum[whs_pkg::RAMP_W-1:0];
				if (ramp_d > whs_pkg::RAMP_W'(whs_pkg::MAX_HEATER_MV))
					volts = whs_pkg::VOLT_W'(whs_pkg::MAX_HEATER_MV);
				else
					volts = ramp_d[whs_pkg::VOLT_W-1:0];
			end
			whs_pkg::ST_RUNNING: begin
				if (item.pid_mv[15])
					volts = '0;
				else if ({1'b0, item.pid_mv[14:0]} > 16'(whs_pkg::MAX_HEATER_MV))
					volts = whs_pkg::VOLT_W'(whs_pkg::MAX_HEATER_MV);
				else
					volts = item.pid_mv[14:0];
			end
			default: volts = '0;
		endcase
	end

	// job handed to the duty unit
	always_comb begin
		job.state = state_d;
		job.err   = err_d;
		job.volts = volts;
		job.vbatt = item.vbatt_mv;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whs_pkg::ST_IDLE;
			err_q   <= whs_pkg::ERR_NONE;
			ticks_q <= '0;
			ramp_q  <= '0;
		end else if (push) begin
			state_q <= state_d;
			err_q   <= err_d;
			ticks_q <= ticks_d;
			ramp_q  <= ramp_d;
		end
	end

`ifndef SYNTHESIS
	// an error code is only carried into error or, later, disabled
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != whs_pkg::ERR_NONE) |->
		(state_q == whs_pkg::ST_ERROR || state_q == whs_pkg::ST_DISABLED))
		else $error("error code latched outside error or disabled");

	// the error state always carries a reason
	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == whs_pkg::ST_ERROR) |-> (err_q != whs_pkg::ERR_NONE))
		else $error("error state without an error code");
`endif

endmodule

// ===== hw/rtl/whs_queue.sv =====
// ----------------------------------------------------------------------------
// whs_queue
// short first-in first-out queue of jobs between sequencer and duty unit
// ----------------------------------------------------------------------------
module whs_queue #(
	parameter int DEPTH = whs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  whs_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output whs_pkg::job_t head_job,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	whs_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("job queue count out of range");
`endif

endmodule

// ===== hw/rtl/whs_back.sv =====
// ----------------------------------------------------------------------------
// whs_back
// duty unit: squares the voltages, divides bit by bit, holds the result
// ----------------------------------------------------------------------------
module whs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  whs_pkg::job_t      head_job,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output whs_pkg::out_item_t result
);

	localparam int CNT_W = $clog2(whs_pkg::DIV_STEPS);

	whs_pkg::back_state_t          bst_q, bst_d;
	whs_pkg::job_t                 job_q;
	logic [whs_pkg::SQ_W:0]        rem_q, rem_shift;
	logic [whs_pkg::SQ_W-1:0]      den_q;
	logic [whs_pkg::DUTY_W-1:0]    quo_q, held_q, duty;
	logic [CNT_W-1:0]              cnt_q;
	logic                          load_out, take_job;
	logic                          result_valid_q;
	whs_pkg::out_item_t            result_q;
	logic                          is_disabled;

	assign rem_shift    = {rem_q[whs_pkg::SQ_W-1:0], 1'b0};
	assign is_disabled  = (job_q.state == whs_pkg::ST_DISABLED);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// next state
	always_comb begin
		bst_d = bst_q;
		case (bst_q)
			whs_pkg::B_IDLE:   if (!empty) bst_d = whs_pkg::B_SQUARE;
			whs_pkg::B_SQUARE: bst_d = whs_pkg::B_DIVIDE;
			whs_pkg::B_DIVIDE: if (cnt_q == CNT_W'(whs_pkg::DIV_STEPS - 1)) bst_d = whs_pkg::B_DONE;
			whs_pkg::B_DONE:   if (!result_valid_q || result_ready) bst_d = whs_pkg::B_IDLE;
			default:           bst_d = whs_pkg::B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		take_job = 1'b0;
		load_out = 1'b0;
		case (bst_q)
			whs_pkg::B_IDLE: take_job = !empty;
			whs_pkg::B_DONE: load_out = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	assign pop = take_job;

	// duty select: held value when disabled, zero when v is zero, saturation when v >= vbatt
	always_comb begin
		if (is_disabled)
			duty = held_q;
		else if (job_q.volts == '0)
			duty = '0;
		else if (job_q.volts >= job_q.vbatt)
			duty = '1;
		else
			duty = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bst_q <= whs_pkg::B_IDLE;
		else
			bst_q <= bst_d;
	end

	// datapath: job capture, squares, restoring division
	always_ff @(posedge clk) begin
		if (take_job)
			job_q <= head_job;
		case (bst_q)
			whs_pkg::B_SQUARE: begin
				rem_q <= (whs_pkg::SQ_W + 1)'(job_q.volts * job_q.volts);
				den_q <= whs_pkg::SQ_W'(job_q.vbatt * job_q.vbatt);
				quo_q <= '0;
				cnt_q <= '0;
			end
			whs_pkg::B_DIVIDE: begin
				if (rem_shift >= {1'b0, den_q}) begin
					rem_q <= rem_shift - {1'b0, den_q};
					quo_q <= {quo_q[whs_pkg::DUTY_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift;
					quo_q <= {quo_q[whs_pkg::DUTY_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// held duty for the disabled state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (load_out && !is_disabled)
			held_q <= duty;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (load_out)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.sensor_state_out <= job_q.state;
			result_q.error_code       <= job_q.err;
			result_q.heater_mv        <= is_disabled ? '0 : job_q.volts[13:0];
			result_q.heater_duty      <= duty;
		end
	end

endmodule

// ===== hw/rtl/wideband_heater_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// wideband_heater_sequencer_unit
// lambda sensor heater sequencer with heater pwm duty output
// ----------------------------------------------------------------------------
// One tick item enters on item/item_valid/item_ready and one result leaves on
// result/result_valid/result_ready for every tick, in order. The sequencer
// takes a tick, updates state, tick count, ramp and latched error, and
// queues the chosen heater voltage. The duty unit computes (V/Vbatt)^2 in
// Q0.16 with a 16-step restoring divider: an item passes fetch, square, 16
// divide steps and output, and no new item is fetched before the last one
// has been handed to the output register. The queue lets ticks be taken
// while the divider works, item_ready drops only when it is full. A stalled
// receiver keeps the result in the output register; the next result waits
// in the duty unit and the queue then fills. Reset puts the sequencer in
// idle with no error, clears the held duty and loads the default thresholds
// with the block disabled; enable must be written over the apb-style port
// before heating starts.
// ----------------------------------------------------------------------------
module wideband_heater_sequencer_unit #(
	parameter int QUEUE_DEPTH = whs_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [whs_pkg::PADDR_W-1:0] paddr,
	input  logic [whs_pkg::PDATA_W-1:0] pwdata,
	output logic [whs_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  whs_pkg::in_item_t           item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output whs_pkg::out_item_t          result
);

	whs_pkg::cfg_t cfg;
	whs_pkg::job_t push_job, head_job;
	logic          push, pop, full, empty;

	// configuration registers
	whs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	whs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	// job queue
	whs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	// duty unit
	whs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
